// ===== sv/clc_pkg.sv =====
// Package for the classical letter cipher block: widths, register indexes,
// character codes and the small modulo-26 helper. No dependencies.
package clc_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned KeyLetterW    = 5;
  localparam int unsigned LettersPerReg = 12;
  localparam int unsigned KeyRegW       = LettersPerReg * KeyLetterW;
  localparam int unsigned MaxKeyLetters = 2 * LettersPerReg;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = KeyRegW;

  localparam logic [KeyLetterW-1:0] MaxKeyLen    = KeyLetterW'(MaxKeyLetters);
  localparam logic [KeyLetterW-1:0] AlphabetSize = KeyLetterW'(26);

  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCipherMode = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEncrypt    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCaesarSh   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyLength  = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyLow     = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh    = 8'd5;

  // Cipher mode codes
  localparam logic ModeCaesar   = 1'b0;
  localparam logic ModeVigenere = 1'b1;

  // Reduce a 5-bit shift into 0..25.
  function automatic logic [KeyLetterW-1:0] mod26(input logic [KeyLetterW-1:0] v);
    logic [KeyLetterW-1:0] r;
    r = (v >= AlphabetSize) ? (v - AlphabetSize) : v;
    return r;
  endfunction

endpackage

// ===== sv/classical_letter_cipher_top.sv =====
// Top level of the classical letter cipher (Caesar / Vigenere) stream block.
// Depends on clc_pkg for widths, register indexes and the modulo-26 helper.
// Holds the configuration registers, key position, cipher datapath and output register.

// Usage: one ASCII byte enters per transfer on the slave side and exactly one
// byte leaves on the master side, in order, in the next cycle at the
// earliest. The block sustains one byte per clock: the whole cipher step (letter
// detect, key letter select, add or subtract modulo 26) sits between the input
// handshake and a single output register, and the key position updates in the
// same cycle, so a new byte is taken every cycle while the output register is
// free or being drained. Letters A-Z and a-z are shifted within their own case;
// all other bytes pass unchanged and do not advance the key. In Vigenere mode
// the shift is the current key letter and the key position steps on letters
// only; in Caesar mode the fixed shift is used and the position holds. After a
// byte with tlast set the key position returns to zero. Shift values 26..31
// act as 0..5; a key length of 0 acts as 1 and above 24 acts as 24. Write the
// configuration only while no transfer is in flight; writes leave the key
// position alone. The configuration channel is always ready.
module classical_letter_cipher_top
  import clc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] in_char
  input  logic                s_axis_tlast,   // last_of_message
  // output byte stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [CharW-1:0]    m_axis_tdata,   // [7:0] out_char
  output logic                m_axis_tlast    // last_out
);

  // Configuration registers
  logic                  mode_q;
  logic                  encrypt_q;
  logic [KeyLetterW-1:0] caesar_q;
  logic [KeyLetterW-1:0] key_len_q;
  logic [KeyRegW-1:0]    key_lo_q;
  logic [KeyRegW-1:0]    key_hi_q;

  // Stream state
  logic [KeyLetterW-1:0] key_pos_q, key_pos_d;
  logic                  out_valid_q;
  logic [CharW-1:0]      out_char_q, out_char_d;
  logic                  out_last_q;

  logic                  in_xfer;
  logic                  cfg_xfer;

  logic                  is_upper, is_lower, is_letter;
  logic [CharW-1:0]      base;
  logic [CharW-1:0]      offset_full;
  logic [KeyLetterW-1:0] offset;
  logic [KeyLetterW-1:0] eff_len;
  logic [KeyLetterW-1:0] pos_use;
  logic [KeyLetterW-1:0] pos_inc;
  logic [KeyLetterW-1:0] pos_next;
  logic [KeyLetterW-1:0] key_letter [MaxKeyLetters];
  logic [KeyLetterW-1:0] shift;
  logic [KeyLetterW:0]   sum;
  logic [KeyLetterW:0]   wrapped;

  // Output register frees up when empty or when it drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  // Unpack the two key registers into letter slots.
  always_comb begin
    for (int i = 0; i < LettersPerReg; i++) begin
      key_letter[i]                 = key_lo_q[i*KeyLetterW +: KeyLetterW];
      key_letter[i + LettersPerReg] = key_hi_q[i*KeyLetterW +: KeyLetterW];
    end
  end

  // Cipher datapath
  always_comb begin
    is_upper    = (s_axis_tdata >= CharUpperA) && (s_axis_tdata <= CharUpperZ);
    is_lower    = (s_axis_tdata >= CharLowerA) && (s_axis_tdata <= CharLowerZ);
    is_letter   = is_upper || is_lower;
    base        = is_upper ? CharUpperA : CharLowerA;
    offset_full = s_axis_tdata - base;
    offset      = offset_full[KeyLetterW-1:0];

    // Clamp key length into 1..MaxKeyLetters.
    if (key_len_q == '0) begin
      eff_len = KeyLetterW'(1);
    end else if (key_len_q > MaxKeyLen) begin
      eff_len = MaxKeyLen;
    end else begin
      eff_len = key_len_q;
    end

    // Wrap a stale position (length lowered mid-message) before the read.
    pos_use  = (key_pos_q >= eff_len) ? '0 : key_pos_q;
    pos_inc  = pos_use + KeyLetterW'(1);
    pos_next = (pos_inc >= eff_len) ? '0 : pos_inc;

    shift = (mode_q == ModeVigenere) ? mod26(key_letter[pos_use]) : mod26(caesar_q);

    if (encrypt_q) begin
      sum = {1'b0, offset} + {1'b0, shift};
    end else begin
      sum = {1'b0, offset} + ({1'b0, AlphabetSize} - {1'b0, shift});
    end
    wrapped = (sum >= {1'b0, AlphabetSize}) ? (sum - {1'b0, AlphabetSize}) : sum;

    out_char_d = is_letter ? (base + CharW'(wrapped)) : s_axis_tdata;

    // Hold position on non-letters and in Caesar mode; drop to zero after last.
    key_pos_d = key_pos_q;
    if (s_axis_tlast) begin
      key_pos_d = '0;
    end else if (is_letter && (mode_q == ModeVigenere)) begin
      key_pos_d = pos_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeVigenere;
      encrypt_q <= 1'b1;
      caesar_q  <= KeyLetterW'(3);
      key_len_q <= KeyLetterW'(1);
      key_lo_q  <= '0;
      key_hi_q  <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CfgCipherMode: mode_q    <= cfg_data_i[0];
        CfgEncrypt:    encrypt_q <= cfg_data_i[0];
        CfgCaesarSh:   caesar_q  <= cfg_data_i[KeyLetterW-1:0];
        CfgKeyLength:  key_len_q <= cfg_data_i[KeyLetterW-1:0];
        CfgKeyLow:     key_lo_q  <= cfg_data_i[KeyRegW-1:0];
        CfgKeyHigh:    key_hi_q  <= cfg_data_i[KeyRegW-1:0];
        default: ;
      endcase
    end
  end

  // Key position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        key_pos_q   <= key_pos_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: load on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_char_q <= out_char_d;
      out_last_q <= s_axis_tlast;
    end
  end

`ifndef NO_ASSERTIONS
  // A transfer marked last leaves the key position at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast |=> key_pos_q == '0)
    else $error("key position not cleared after last byte");

  // Non-letters come out unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !is_letter |=> m_axis_tdata == $past(s_axis_tdata))
    else $error("non-letter byte altered");

  // Caesar mode never moves the key position except at message end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (mode_q == ModeCaesar) && !s_axis_tlast |=> $stable(key_pos_q))
    else $error("key position moved in Caesar mode");

  // Every accepted byte produces a pending result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("accepted byte produced no result");
`endif

endmodule
